// ===== src/beq_pkg.sv =====
// ----------------------------------------------------------------------------
// beq_pkg: shared types and constants of the block echo with band equalizer
// types for the configuration set, the queued work item and the back-end
// state machine, plus the octave band gain lookup
// ----------------------------------------------------------------------------
`default_nettype none

package beq_pkg;

    // default geometry of the echo ring
    localparam int DEF_BLOCK_LEN   = 256;
    localparam int DEF_RING_BLOCKS = 16;

    // widest position and store address any geometry needs
    localparam int POS_MAX_W  = 8;
    localparam int ADDR_MAX_W = 16;

    // number of codes of the 4-bit delay offset register
    localparam int OFFSET_CODES = 16;

    // queue depths
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 16;

    localparam logic signed [SAMPLE_W-1:0] S24_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] S24_MIN = 24'sh800000;

    // Q2.14 scaling shift
    localparam int Q14_SHIFT = 14;

    // reset values
    localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'h4000;
    localparam logic [63:0]       GAINS4_UNITY = 64'h4000_4000_4000_4000;

    // configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_ECHO_ENABLE    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_STORE_MODE     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DELAY_OFFSET   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ECHO_LEVEL     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BAND_GAINS_0_3 = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_BAND_GAINS_4_7 = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_BAND_GAIN_8    = 3'd6;

    // store scaling mode
    localparam logic MODE_LEVEL = 1'b0;
    localparam logic MODE_BANDS = 1'b1;

    typedef enum logic
    {
        KIND_SAMPLE = 1'b0,
        KIND_CLEAR  = 1'b1
    } cmd_kind_t;

    typedef enum logic [1:0]
    {
        BK_RUN   = 2'd0,
        BK_DRAIN = 2'd1,
        BK_CLEAR = 2'd2
    } back_state_t;

    typedef struct packed
    {
        logic        echo_enable;
        logic        store_mode;
        logic [3:0]  delay_offset;
        logic [15:0] echo_level;
        logic [63:0] band_gains_0_3;
        logic [63:0] band_gains_4_7;
        logic [15:0] band_gain_8;
    } cfg_t;

    // one classified item on its way from the front end to the back end
    typedef struct packed
    {
        cmd_kind_t                    kind;
        logic                         en;
        logic                         last;
        logic signed [SAMPLE_W-1:0]   sample;
        logic [GAIN_W-1:0]            gain;
        logic [ADDR_MAX_W-1:0]        rd_addr;
        logic [ADDR_MAX_W-1:0]        wr_addr;
    } item_t;

    // octave band of a position is its bit length; band 8 covers 128..255
    function automatic logic [GAIN_W-1:0] band_gain(
        input logic [POS_MAX_W-1:0] pos,
        input logic [63:0]          g03,
        input logic [63:0]          g47,
        input logic [GAIN_W-1:0]    g8
    );
        logic [3:0]        band;
        logic [GAIN_W-1:0] gain;
        band = '0;
        for (int i = 0; i < POS_MAX_W; i++)
        begin
            if (pos[i])
            begin
                band = 4'(i + 1);
            end
        end
        case (band)
            4'd0:    gain = g03[15:0];
            4'd1:    gain = g03[31:16];
            4'd2:    gain = g03[47:32];
            4'd3:    gain = g03[63:48];
            4'd4:    gain = g47[15:0];
            4'd5:    gain = g47[31:16];
            4'd6:    gain = g47[47:32];
            4'd7:    gain = g47[63:48];
            default: gain = g8;
        endcase
        return gain;
    endfunction

endpackage

`default_nettype wire

// ===== src/beq_queue.sv =====
// ----------------------------------------------------------------------------
// beq_queue: small register fifo
// valid/ready on both sides, power-of-two depth, occupancy count output
// ----------------------------------------------------------------------------
`default_nettype none

module beq_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push_valid,
    output logic                       push_ready,
    input  logic [WIDTH-1:0]           push_data,
    output logic                       pop_valid,
    input  logic                       pop_ready,
    output logic [WIDTH-1:0]           pop_data,
    output logic [$clog2(DEPTH):0]     count
);

    localparam int PTW = $clog2(DEPTH);
    localparam int CW  = PTW + 1;

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

    assign do_push = push_valid & push_ready;
    assign do_pop  = pop_valid & pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/beq_front.sv =====
// ----------------------------------------------------------------------------
// beq_front: input side of the echo unit
// takes input transfers, tracks block position and write slot, works out
// the store addresses and the store gain, and queues the classified item
// ----------------------------------------------------------------------------
`default_nettype none

module beq_front
    import beq_pkg::*;
#(
    parameter int BLOCK_LEN   = DEF_BLOCK_LEN,
    parameter int RING_BLOCKS = DEF_RING_BLOCKS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                clearing,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [23:0]         s_axis_tdata,   // sample_in
    input  logic [0:0]          s_axis_tuser,   // command
    output logic                item_valid,
    input  logic                item_ready,
    output item_t               item
);

    localparam int PW = $clog2(BLOCK_LEN);
    localparam int BW = (RING_BLOCKS > 1) ? $clog2(RING_BLOCKS) : 1;

    logic [PW-1:0] pos_reg, pos_next;
    logic [BW-1:0] wb_reg, wb_next;
    logic [BW-1:0] back_lut [OFFSET_CODES];
    logic [BW-1:0] back;
    logic [BW:0]   rb_wide;
    logic [BW-1:0] rb;
    logic          last;
    logic          accept;
    cmd_kind_t     kind;

    // offset modulo ring size, fixed at elaboration
    for (genvar gi = 0; gi < OFFSET_CODES; gi++)
    begin : g_back
        assign back_lut[gi] = BW'(gi % RING_BLOCKS);
    end

    assign kind          = cmd_kind_t'(s_axis_tuser[0]);
    assign item_valid    = s_axis_tvalid & ~clearing;
    assign s_axis_tready = item_ready & ~clearing;
    assign accept        = s_axis_tvalid & s_axis_tready;

    assign back = back_lut[cfg.delay_offset];
    assign last = (pos_reg == PW'(BLOCK_LEN - 1));

    always_comb
    begin
        if (wb_reg >= back)
        begin
            rb_wide = {1'b0, wb_reg} - {1'b0, back};
        end
        else
        begin
            rb_wide = {1'b0, wb_reg} + (BW + 1)'(RING_BLOCKS) - {1'b0, back};
        end
    end
    assign rb = rb_wide[BW-1:0];

    always_comb
    begin
        item.kind    = kind;
        item.en      = cfg.echo_enable;
        item.last    = last;
        item.sample  = s_axis_tdata;
        item.gain    = (cfg.store_mode == MODE_BANDS)
                     ? band_gain(POS_MAX_W'(pos_reg), cfg.band_gains_0_3,
                                 cfg.band_gains_4_7, cfg.band_gain_8)
                     : cfg.echo_level;
        item.rd_addr = ADDR_MAX_W'({rb, pos_reg});
        item.wr_addr = ADDR_MAX_W'({wb_reg, pos_reg});
    end

    always_comb
    begin
        pos_next = pos_reg;
        wb_next  = wb_reg;
        if (accept)
        begin
            if (kind == KIND_CLEAR)
            begin
                pos_next = '0;
                wb_next  = '0;
            end
            else
            begin
                pos_next = last ? '0 : pos_reg + 1'b1;
                if (cfg.echo_enable && last)
                begin
                    wb_next = (wb_reg == BW'(RING_BLOCKS - 1)) ? '0 : wb_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            wb_reg  <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            wb_reg  <= wb_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/beq_back.sv =====
// ----------------------------------------------------------------------------
// beq_back: execution side of the echo unit
// echo store, read, saturating add, Q2.14 scaling pipeline, store
// write-back, clear sweep and the output fifo
// ----------------------------------------------------------------------------
`default_nettype none

module beq_back
    import beq_pkg::*;
#(
    parameter int BLOCK_LEN   = DEF_BLOCK_LEN,
    parameter int RING_BLOCKS = DEF_RING_BLOCKS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  item_t               item,
    output logic                clearing,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [23:0]         m_axis_tdata,   // sample_out
    output logic                m_axis_tlast    // block_end
);

    localparam int PW        = $clog2(BLOCK_LEN);
    localparam int BW        = (RING_BLOCKS > 1) ? $clog2(RING_BLOCKS) : 1;
    localparam int AW        = PW + BW;
    localparam int MEM_DEPTH = 1 << AW;
    localparam int OCW       = $clog2(OUT_DEPTH) + 1;
    localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;

    logic signed [SAMPLE_W-1:0] store_mem [MEM_DEPTH];

    back_state_t state_reg, state_next;
    logic [AW-1:0] sweep_reg, sweep_next;

    logic signed [SAMPLE_W-1:0] rdata_reg;

    logic                       b_v_reg, b_en_reg, b_last_reg;
    logic signed [SAMPLE_W-1:0] b_x_reg;
    logic [GAIN_W-1:0]          b_gain_reg;
    logic [AW-1:0]              b_waddr_reg;

    logic                       c_v_reg;
    logic signed [SAMPLE_W-1:0] c_y_reg;
    logic [GAIN_W-1:0]          c_gain_reg;
    logic [AW-1:0]              c_waddr_reg;

    logic                       d_v_reg;
    logic signed [PROD_W-1:0]   d_prod_reg;
    logic [AW-1:0]              d_waddr_reg;

    logic [AW-1:0]              rd_addr;
    logic                       hazard;
    logic                       credit;
    logic                       issue;
    logic                       sweep_we;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic signed [SAMPLE_W-1:0] mem_wdata;

    logic signed [SAMPLE_W:0]   sum;
    logic signed [SAMPLE_W-1:0] b_y;
    logic signed [PROD_W-1:0]   c_prod;
    logic signed [PROD_W-1:0]   d_round;
    logic signed [PROD_W-1:0]   d_q;
    logic signed [SAMPLE_W-1:0] d_result;

    logic                       out_push_ready;
    logic [SAMPLE_W:0]          out_pop_data;
    logic [OCW-1:0]             out_count;

    assign rd_addr  = item.rd_addr[AW-1:0];
    assign clearing = (state_reg == BK_CLEAR);

    // a read must not overtake a pending write-back to the same word
    assign hazard = item.en &&
                    ((b_v_reg && b_en_reg && (b_waddr_reg == rd_addr)) ||
                     (c_v_reg && (c_waddr_reg == rd_addr)) ||
                     (d_v_reg && (d_waddr_reg == rd_addr)));

    // room in the output fifo for everything already issued
    assign credit = (out_count + OCW'(b_v_reg)) < OCW'(OUT_DEPTH);

    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        issue      = 1'b0;
        item_ready = 1'b0;
        sweep_we   = 1'b0;
        case (state_reg)
            BK_RUN:
            begin
                if (item_valid)
                begin
                    if (item.kind == KIND_CLEAR)
                    begin
                        item_ready = 1'b1;
                        state_next = BK_DRAIN;
                    end
                    else if (!hazard && credit)
                    begin
                        item_ready = 1'b1;
                        issue      = 1'b1;
                    end
                end
            end
            BK_DRAIN:
            begin
                if (!b_v_reg && !c_v_reg && !d_v_reg)
                begin
                    state_next = BK_CLEAR;
                    sweep_next = '0;
                end
            end
            BK_CLEAR:
            begin
                sweep_we   = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == {AW{1'b1}})
                begin
                    state_next = BK_RUN;
                end
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_CLEAR;
            sweep_reg <= '0;
            b_v_reg   <= 1'b0;
            c_v_reg   <= 1'b0;
            d_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            b_v_reg   <= issue;
            c_v_reg   <= b_v_reg & b_en_reg;
            d_v_reg   <= c_v_reg;
        end
    end

    // store: one write port, one registered read port
    assign mem_we    = sweep_we | d_v_reg;
    assign mem_waddr = sweep_we ? sweep_reg : d_waddr_reg;
    assign mem_wdata = sweep_we ? '0 : d_result;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (issue)
        begin
            rdata_reg <= store_mem[rd_addr];
        end
    end

    // stage b: add the delayed word and saturate, or pass the sample when echo is off
    always_comb
    begin
        sum = {b_x_reg[SAMPLE_W-1], b_x_reg} + {rdata_reg[SAMPLE_W-1], rdata_reg};
        if (!b_en_reg)
        begin
            b_y = b_x_reg;
        end
        else if (sum[SAMPLE_W] != sum[SAMPLE_W-1])
        begin
            b_y = sum[SAMPLE_W] ? S24_MIN : S24_MAX;
        end
        else
        begin
            b_y = sum[SAMPLE_W-1:0];
        end
    end

    // stage c: multiply by the unsigned gain
    assign c_prod = PROD_W'(c_y_reg) * $signed({1'b0, c_gain_reg});

    // stage d: round half up, drop 14 fraction bits, saturate
    always_comb
    begin
        d_round = d_prod_reg + PROD_W'(1 << (Q14_SHIFT - 1));
        d_q     = d_round >>> Q14_SHIFT;
        if (d_q > PROD_W'(S24_MAX))
        begin
            d_result = S24_MAX;
        end
        else if (d_q < PROD_W'(S24_MIN))
        begin
            d_result = S24_MIN;
        end
        else
        begin
            d_result = d_q[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_en_reg    <= item.en;
            b_last_reg  <= item.last;
            b_x_reg     <= item.sample;
            b_gain_reg  <= item.gain;
            b_waddr_reg <= item.wr_addr[AW-1:0];
        end
        c_y_reg     <= b_y;
        c_gain_reg  <= b_gain_reg;
        c_waddr_reg <= b_waddr_reg;
        d_prod_reg  <= c_prod;
        d_waddr_reg <= c_waddr_reg;
    end

    beq_queue
    #(
        .WIDTH (SAMPLE_W + 1),
        .DEPTH (OUT_DEPTH)
    )
    u_out_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (b_v_reg),
        .push_ready (out_push_ready),
        .push_data  ({b_last_reg, b_y}),
        .pop_valid  (m_axis_tvalid),
        .pop_ready  (m_axis_tready),
        .pop_data   (out_pop_data),
        .count      (out_count)
    );

    assign m_axis_tdata = out_pop_data[SAMPLE_W-1:0];
    assign m_axis_tlast = out_pop_data[SAMPLE_W];

    // a result leaving stage b always finds room in the output fifo
    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        b_v_reg |-> out_push_ready)
        else $error("output fifo full at result push");

    // the clear sweep never races a pending write-back
    a_sweep_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_CLEAR) |-> (!b_v_reg && !c_v_reg && !d_v_reg))
        else $error("store write-back during clear sweep");

    // no sample is issued once a clear has been taken
    a_drain_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DRAIN) |-> !b_v_reg)
        else $error("sample issued behind a clear");

    // write-back stage is fed only by the multiply stage
    a_wb_order: assert property (@(posedge clk) disable iff (!rst_n)
        d_v_reg |-> $past(c_v_reg))
        else $error("write-back without a product");

endmodule

`default_nettype wire

// ===== src/block_echo_with_band_eq_unit.sv =====
// path: an accepted input passes the front-to-back queue, stage b and the output fifo to m_axis
// throughput: one sample per cycle while m_axis is ready; a sample waits only while a
//   write-back to the word it reads is in flight (block lengths of three or less)
// clear: pipeline drain, then a sweep of one store word per cycle over all 4096 words at the
//   defaults (2**(clog2(BLOCK_LEN)+clog2(RING_BLOCKS))), no input taken during the sweep
// reset: control state cleared at once, the same sweep runs before the first input transfer
// ----------------------------------------------------------------------------
// block_echo_with_band_eq_unit: feedback echo over a ring of sample blocks
// each sample adds the stored word at its position some blocks back, the
// saturated sum is the result and, scaled by a Q2.14 level or octave band
// gain, is written back into the current block slot
// ----------------------------------------------------------------------------
`default_nettype none

module block_echo_with_band_eq_unit
    import beq_pkg::*;
#(
    parameter int BLOCK_LEN   = DEF_BLOCK_LEN,     // samples per block, 2..256
    parameter int RING_BLOCKS = DEF_RING_BLOCKS    // blocks in the ring, 1..256
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    // configuration write port
    input  logic                    cfg_we,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [63:0]             cfg_wdata,

    // sample stream in
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [23:0]             s_axis_tdata,   // sample_in
    input  logic [0:0]              s_axis_tuser,   // command

    // result stream out
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [23:0]             m_axis_tdata,   // sample_out
    output logic                    m_axis_tlast    // block_end
);

    // configuration registers
    logic        echo_enable_reg;
    logic        store_mode_reg;
    logic [3:0]  delay_offset_reg;
    logic [15:0] echo_level_reg;
    logic [63:0] band_gains_0_3_reg;
    logic [63:0] band_gains_4_7_reg;
    logic [15:0] band_gain_8_reg;
    cfg_t        cfg;

    // front to back queue
    logic        fq_push_valid;
    logic        fq_push_ready;
    item_t       fq_push_item;
    logic        fq_pop_valid;
    logic        fq_pop_ready;
    logic [$bits(item_t)-1:0] fq_pop_data;
    item_t       fq_pop_item;

    logic        clearing;

    // register writes; the user must write only while the unit is idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_enable_reg    <= 1'b0;
            store_mode_reg     <= MODE_LEVEL;
            delay_offset_reg   <= '0;
            echo_level_reg     <= GAIN_UNITY;
            band_gains_0_3_reg <= GAINS4_UNITY;
            band_gains_4_7_reg <= GAINS4_UNITY;
            band_gain_8_reg    <= GAIN_UNITY;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ECHO_ENABLE:    echo_enable_reg    <= cfg_wdata[0];
                REG_STORE_MODE:     store_mode_reg     <= cfg_wdata[0];
                REG_DELAY_OFFSET:   delay_offset_reg   <= cfg_wdata[3:0];
                REG_ECHO_LEVEL:     echo_level_reg     <= cfg_wdata[15:0];
                REG_BAND_GAINS_0_3: band_gains_0_3_reg <= cfg_wdata;
                REG_BAND_GAINS_4_7: band_gains_4_7_reg <= cfg_wdata;
                REG_BAND_GAIN_8:    band_gain_8_reg    <= cfg_wdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.echo_enable    = echo_enable_reg;
        cfg.store_mode     = store_mode_reg;
        cfg.delay_offset   = delay_offset_reg;
        cfg.echo_level     = echo_level_reg;
        cfg.band_gains_0_3 = band_gains_0_3_reg;
        cfg.band_gains_4_7 = band_gains_4_7_reg;
        cfg.band_gain_8    = band_gain_8_reg;
    end

    // front end: position and slot tracking, address and gain selection
    beq_front
    #(
        .BLOCK_LEN   (BLOCK_LEN),
        .RING_BLOCKS (RING_BLOCKS)
    )
    u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .clearing      (clearing),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .item_valid    (fq_push_valid),
        .item_ready    (fq_push_ready),
        .item          (fq_push_item)
    );

    // decoupling queue so the front keeps taking transfers while the back stalls
    beq_queue
    #(
        .WIDTH ($bits(item_t)),
        .DEPTH (MID_DEPTH)
    )
    u_mid_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_push_valid),
        .push_ready (fq_push_ready),
        .push_data  (fq_push_item),
        .pop_valid  (fq_pop_valid),
        .pop_ready  (fq_pop_ready),
        .pop_data   (fq_pop_data),
        .count      ()
    );

    assign fq_pop_item = item_t'(fq_pop_data);

    // back end: store access, add, scale, write-back, output fifo
    beq_back
    #(
        .BLOCK_LEN   (BLOCK_LEN),
        .RING_BLOCKS (RING_BLOCKS)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (fq_pop_valid),
        .item_ready    (fq_pop_ready),
        .item          (fq_pop_item),
        .clearing      (clearing),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the block echo with band equalizer
// an in-bench echo scoreboard tracks the ring store, slot and position and
// predicts every result; random samples, clears, register phases, idling on
// both streams and one long output hold-off exercise the block
// ----------------------------------------------------------------------------

module tb;
    import beq_pkg::*;

    localparam int STORE_WORDS  = DEF_BLOCK_LEN * DEF_RING_BLOCKS;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 222;
    localparam int LONG_HOLD    = 400;       // output hold-off, fills the block
    localparam int SETTLE       = 8;         // > write-back delay after the last result
    localparam int TAIL_CYCLES  = 16;
    localparam int LIMIT_CYCLES = 1000000;

    // one result transfer as seen on m_axis
    typedef struct packed
    {
        logic [SAMPLE_W-1:0] sample;
        logic                block_end;
    } echo_out_t;

    // ------------------------------------------------------------------------
    // echo scoreboard: own copy of store, write slot, position and registers
    // ------------------------------------------------------------------------
    class echo_scoreboard;
        logic signed [SAMPLE_W-1:0] store [STORE_WORDS];
        int                         wr_block;
        int                         position;
        cfg_t                       regs;
        echo_out_t                  echo_out_q [$];
        int                         mismatch_count;

        function new();
            foreach (store[i])
            begin
                store[i] = '0;
            end
            wr_block            = 0;
            position            = 0;
            regs.echo_enable    = 1'b0;
            regs.store_mode     = MODE_LEVEL;
            regs.delay_offset   = '0;
            regs.echo_level     = GAIN_UNITY;
            regs.band_gains_0_3 = GAINS4_UNITY;
            regs.band_gains_4_7 = GAINS4_UNITY;
            regs.band_gain_8    = GAIN_UNITY;
            mismatch_count      = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [63:0] value);
            case (idx)
                REG_ECHO_ENABLE:    regs.echo_enable    = value[0];
                REG_STORE_MODE:     regs.store_mode     = value[0];
                REG_DELAY_OFFSET:   regs.delay_offset   = value[3:0];
                REG_ECHO_LEVEL:     regs.echo_level     = value[15:0];
                REG_BAND_GAINS_0_3: regs.band_gains_0_3 = value;
                REG_BAND_GAINS_4_7: regs.band_gains_4_7 = value;
                REG_BAND_GAIN_8:    regs.band_gain_8    = value[15:0];
                default:            ;
            endcase
        endfunction

        function logic signed [SAMPLE_W-1:0] clip24(longint v);
            if (v > longint'(S24_MAX))
            begin
                return S24_MAX;
            end
            if (v < longint'(S24_MIN))
            begin
                return S24_MIN;
            end
            return v[SAMPLE_W-1:0];
        endfunction

        // Q2.14 product, rounded half up, i.e. floor((p + 8192) / 16384)
        function logic signed [SAMPLE_W-1:0] apply_gain(logic signed [SAMPLE_W-1:0] v,
                                                        logic [GAIN_W-1:0] gain);
            longint p;
            p = longint'(v) * longint'(gain) + (longint'(1) <<< (Q14_SHIFT - 1));
            return clip24(p >>> Q14_SHIFT);
        endfunction

        // octave bands start at 0,1,2,4,...,128
        function logic [GAIN_W-1:0] octave_gain(int pos);
            int band;
            band = 0;
            for (int i = 0; i < POS_MAX_W; i++)
            begin
                if (pos >= (1 << i))
                begin
                    band = i + 1;
                end
            end
            if (band < 4)
            begin
                return regs.band_gains_0_3[16*band +: 16];
            end
            if (band < 8)
            begin
                return regs.band_gains_4_7[16*(band-4) +: 16];
            end
            return regs.band_gain_8;
        endfunction

        // accepted input: update state, queue the echo output it causes
        function void predict_echo(cmd_kind_t kind, logic [SAMPLE_W-1:0] raw);
            logic signed [SAMPLE_W-1:0] x;
            logic signed [SAMPLE_W-1:0] y;
            logic [GAIN_W-1:0]          gain;
            logic                       last;
            int                         rd_block;
            echo_out_t                  res;
            if (kind == KIND_CLEAR)
            begin
                foreach (store[i])
                begin
                    store[i] = '0;
                end
                wr_block = 0;
                position = 0;
                return;
            end
            x    = raw;
            last = (position == DEF_BLOCK_LEN - 1);
            if (regs.echo_enable)
            begin
                rd_block = (wr_block + DEF_RING_BLOCKS
                            - (int'(regs.delay_offset) % DEF_RING_BLOCKS)) % DEF_RING_BLOCKS;
                y = clip24(longint'(x) + longint'(store[rd_block*DEF_BLOCK_LEN + position]));
                gain = (regs.store_mode == MODE_BANDS) ? octave_gain(position)
                                                       : regs.echo_level;
                store[wr_block*DEF_BLOCK_LEN + position] = apply_gain(y, gain);
                if (last)
                begin
                    wr_block = (wr_block + 1) % DEF_RING_BLOCKS;
                end
            end
            else
            begin
                y = x;
            end
            position      = last ? 0 : position + 1;
            res.sample    = y;
            res.block_end = last;
            echo_out_q.push_back(res);
        endfunction

        function void check_echo_out(logic [SAMPLE_W-1:0] sample, logic block_end);
            echo_out_t exp_out;
            if (echo_out_q.size() == 0)
            begin
                $display("%0t: unexpected result, sample_out %h block_end %b",
                         $time, sample, block_end);
                mismatch_count++;
                return;
            end
            exp_out = echo_out_q.pop_front();
            if (sample !== exp_out.sample)
            begin
                $display("%0t: sample_out mismatch, expected %h, actual %h",
                         $time, exp_out.sample, sample);
                mismatch_count++;
            end
            if (block_end !== exp_out.block_end)
            begin
                $display("%0t: block_end mismatch, expected %b, actual %b",
                         $time, exp_out.block_end, block_end);
                mismatch_count++;
            end
        endfunction

        function int outstanding();
            return echo_out_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, dut and bench state
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [63:0]           cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata;    // sample_in
    logic [0:0]            s_axis_tuser;    // command
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [23:0]           m_axis_tdata;    // sample_out
    logic                  m_axis_tlast;    // block_end

    echo_scoreboard sb = new();

    int unsigned tx_idle_pct  = 0;   // chance in 100 that the sender skips a cycle
    int unsigned rx_idle_pct  = 0;   // chance in 100 that the receiver stalls
    bit          hold_request = 1'b0;
    int          cycle_count  = 0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    block_echo_with_band_eq_unit u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------------
    // output side: random stalls plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_request)
            begin
                // block fills up and must push back on s_axis meanwhile
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // every result transfer goes straight to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_echo_out(m_axis_tdata, m_axis_tlast);
        end
    end

    // watchdog, far above the slowest legal run
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // driver tasks
    // ------------------------------------------------------------------------

    // one input transfer, with random idle cycles in front of it
    task automatic send_item(cmd_kind_t kind, logic [SAMPLE_W-1:0] data);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= kind;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        sb.predict_echo(kind, data);
    endtask

    // stop offering, then wait for all outstanding results plus settle time
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // register write; cfg_we is left high, the caller lowers it
    task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    task automatic set_config(logic en, logic mode, logic [3:0] offset,
                              logic [15:0] level, logic [63:0] g03,
                              logic [63:0] g47, logic [15:0] g8);
        cfg_write(REG_ECHO_ENABLE, 64'(en));
        cfg_write(REG_STORE_MODE, 64'(mode));
        cfg_write(REG_DELAY_OFFSET, 64'(offset));
        cfg_write(REG_ECHO_LEVEL, 64'(level));
        cfg_write(REG_BAND_GAINS_0_3, g03);
        cfg_write(REG_BAND_GAINS_4_7, g47);
        cfg_write(REG_BAND_GAIN_8, 64'(g8));
        cfg_we <= 1'b0;
    endtask

    // full-range values mostly, plus extremes and small magnitudes
    function automatic logic [SAMPLE_W-1:0] random_sample();
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(7))
            0:
            begin
                case ($urandom_range(3))
                    0:       v = S24_MAX;
                    1:       v = S24_MIN;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            1, 2:
            begin
                v = 24'($urandom_range(2047));
                v = v - 24'sd1024;
            end
            default: v = 24'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [63:0] random_gains();
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_addr      <= '0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_SAMPLE;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // echo disabled after reset: extremes pass through untouched
        send_item(KIND_SAMPLE, 24'h000000);
        send_item(KIND_SAMPLE, 24'h7FFFFF);
        send_item(KIND_SAMPLE, 24'h800000);
        send_item(KIND_SAMPLE, 24'hFFFFFF);
        send_item(KIND_SAMPLE, 24'h000001);
        send_item(KIND_SAMPLE, 24'h555555);
        send_item(KIND_SAMPLE, 24'hAAAAAA);
        wait_drained();

        // largest level, offset zero reads the slot about to be overwritten
        set_config(1'b1, MODE_LEVEL, 4'd0, 16'hFFFF, GAINS4_UNITY, GAINS4_UNITY,
                   GAIN_UNITY);
        send_item(KIND_SAMPLE, 24'h7FFFFF);
        send_item(KIND_SAMPLE, 24'h800000);
        send_item(KIND_SAMPLE, 24'h400000);
        send_item(KIND_SAMPLE, 24'hC00000);
        // clear mid-block restarts framing at position zero
        send_item(KIND_CLEAR, 24'hFFFFFF);
        send_item(KIND_SAMPLE, 24'h7FFFFF);
        send_item(KIND_SAMPLE, 24'h800000);
        wait_drained();

        // band mode, largest offset, zero and full-scale lanes
        set_config(1'b1, MODE_BANDS, 4'd15, 16'h0000, 64'hFFFF_0000_FFFF_0000,
                   64'h0000_FFFF_0000_FFFF, 16'h0001);
        send_item(KIND_SAMPLE, 24'h123456);
        send_item(KIND_SAMPLE, 24'hEDCBA9);
        send_item(KIND_SAMPLE, 24'h7FFFFF);
        send_item(KIND_SAMPLE, 24'h800000);
        send_item(KIND_CLEAR, 24'h000000);
        send_item(KIND_SAMPLE, 24'h000001);
        wait_drained();

        // random phases; register settings change only between phases, so
        // the block framing carries over a switch mid-block
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: set_config(1'b1, MODE_LEVEL, 4'd1, GAIN_UNITY, random_gains(),
                              random_gains(), 16'($urandom));
                1: set_config(1'b1, MODE_BANDS, 4'd0, 16'hFFFF, '1, random_gains(),
                              16'h0000);
                2: set_config(1'b0, 1'($urandom), 4'd15, 16'h0000, random_gains(),
                              random_gains(), 16'($urandom));
                3: set_config(1'b1, MODE_LEVEL, 4'd2, 16'h0000, random_gains(),
                              '0, 16'hFFFF);
                4: set_config(1'b1, MODE_BANDS, 4'd3, 16'($urandom), random_gains(),
                              random_gains(), 16'hFFFF);
                default: set_config(1'b1, MODE_LEVEL, 4'd1, 16'hFFFF, random_gains(),
                                    random_gains(), 16'($urandom));
            endcase

            // slow receiver, then slow sender, then full rate
            case (p / 2)
                0:
                begin
                    tx_idle_pct = 10;
                    rx_idle_pct = 85;
                end
                1:
                begin
                    tx_idle_pct = 85;
                    rx_idle_pct = 10;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            if (p == 4)
            begin
                hold_request = 1'b1;
            end

            // the last item of a phase is a sample, so no clear sweep is
            // still running when the next register writes go in
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i != PHASE_ITEMS - 1 && $urandom_range(149) == 0)
                begin
                    send_item(KIND_CLEAR, 24'($urandom));
                end
                else
                begin
                    send_item(KIND_SAMPLE, random_sample());
                end
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.outstanding() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
